// ===== rtl/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and codes for the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

   // timestamp width; elapsed times wrap at this width
   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;

   typedef logic [TIME_BITS-1:0] stamp_type;
   typedef logic [2:0]           mode_type;
   typedef logic [2:0]           csr_index_type;

   // mode codes; 6 and 7 are unknown and force the LED off
   localparam mode_type MODE_START   = 3'd0;
   localparam mode_type MODE_CONNECT = 3'd1;
   localparam mode_type MODE_ERROR   = 3'd2;
   localparam mode_type MODE_NORMAL  = 3'd3;
   localparam mode_type MODE_SEND    = 3'd4;
   localparam mode_type MODE_OTA     = 3'd5;

   // item kinds
   localparam logic FUNC_POLL  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // register indexes
   localparam csr_index_type REG_CONNECT_HALF = 3'd0;
   localparam csr_index_type REG_ERROR_HALF   = 3'd1;
   localparam csr_index_type REG_BEAT_ON      = 3'd2;
   localparam csr_index_type REG_BEAT_OFF     = 3'd3;
   localparam csr_index_type REG_STEP_TIME    = 3'd4;
   localparam csr_index_type REG_STEP_COUNT   = 3'd5;
   localparam csr_index_type REG_OTA_HALF     = 3'd6;
   localparam csr_index_type REG_ON_LEVEL     = 3'd7;

   typedef struct packed {
      logic [15:0] connect_half_period;
      logic [15:0] error_half_period;
      logic [15:0] beat_on_time;
      logic [15:0] beat_off_time;
      logic [15:0] burst_step_time;
      logic [7:0]  burst_step_count;
      logic [15:0] ota_half_period;
      logic        on_level;
   } cfg_type;

   typedef struct packed {
      logic                func;
      logic [NOW_BITS-1:0] now_ms;
      mode_type            new_mode;
      mode_type            return_mode;
   } item_type;

   typedef struct packed {
      logic     pin_level;
      mode_type mode_now;
   } result_type;

endpackage

// ===== rtl/slpg_csr.sv =====
// ----------------------------------------------------------------------------
// slpg_csr
// Configuration register file for the blink intervals and LED polarity.
// ----------------------------------------------------------------------------
module slpg_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  slpg_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data,
   output slpg_pkg::cfg_type      cfg
);
   import slpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CONNECT_HALF: cfg_in.connect_half_period = csr_data;
            REG_ERROR_HALF:   cfg_in.error_half_period   = csr_data;
            REG_BEAT_ON:      cfg_in.beat_on_time        = csr_data;
            REG_BEAT_OFF:     cfg_in.beat_off_time       = csr_data;
            REG_STEP_TIME:    cfg_in.burst_step_time     = csr_data;
            REG_STEP_COUNT:   cfg_in.burst_step_count    = csr_data[7:0];
            REG_OTA_HALF:     cfg_in.ota_half_period     = csr_data;
            REG_ON_LEVEL:     cfg_in.on_level            = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.connect_half_period <= 16'd500;
         cfg_ff.error_half_period   <= 16'd100;
         cfg_ff.beat_on_time        <= 16'd100;
         cfg_ff.beat_off_time       <= 16'd2900;
         cfg_ff.burst_step_time     <= 16'd50;
         cfg_ff.burst_step_count    <= 8'd10;
         cfg_ff.ota_half_period     <= 16'd125;
         cfg_ff.on_level            <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/slpg_engine.sv =====
// ----------------------------------------------------------------------------
// slpg_engine
// Pattern state and the combinational update for one poll or mode write.
// ----------------------------------------------------------------------------
module slpg_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  slpg_pkg::item_type   item,
   input  slpg_pkg::cfg_type    cfg,
   output slpg_pkg::result_type result
);
   import slpg_pkg::*;

   logic      led_ff,     led_in;
   mode_type  mode_ff,    mode_in;
   mode_type  saved_ff,   saved_in;
   stamp_type last_ff,    last_in;
   stamp_type start_ff,   start_in;
   logic [7:0] step_ff,   step_in;
   logic      running_ff, running_in;

   logic        lit;
   logic        dark;
   stamp_type   now;
   stamp_type   since;
   stamp_type   elapsed;
   logic [15:0] interval;
   logic        hit;
   logic [7:0]  step_cur;
   logic [7:0]  step_next;

   assign lit       = cfg.on_level;
   assign dark      = ~cfg.on_level;
   assign now       = TIME_BITS'(item.now_ms);
   assign step_cur  = running_ff ? step_ff : 8'd0;
   assign step_next = step_cur + 8'd1;

   // interval and reference time chosen by mode (on or off time in normal), one shared compare
   always_comb begin
      interval = cfg.ota_half_period;
      since    = last_ff;
      unique case (mode_ff)
         MODE_CONNECT: interval = cfg.connect_half_period;
         MODE_ERROR:   interval = cfg.error_half_period;
         MODE_NORMAL:  interval = (led_ff == lit) ? cfg.beat_on_time : cfg.beat_off_time;
         MODE_SEND: begin
            interval = cfg.burst_step_time;
            // a fresh burst starts at this timestamp
            since    = running_ff ? start_ff : now;
         end
         default:      interval = cfg.ota_half_period;
      endcase
   end

   assign elapsed = now - since;
   assign hit     = (elapsed >= TIME_BITS'(interval));

   always_comb begin
      led_in     = led_ff;
      mode_in    = mode_ff;
      saved_in   = saved_ff;
      last_in    = last_ff;
      start_in   = start_ff;
      step_in    = step_ff;
      running_in = running_ff;
      if (fire) begin
         if (item.func == FUNC_WRITE) begin
            mode_in  = item.new_mode;
            saved_in = item.return_mode;
         end else begin
            unique case (mode_ff)
               MODE_START: led_in = lit;
               MODE_CONNECT, MODE_ERROR, MODE_OTA: begin
                  if (hit) begin
                     led_in  = ~led_ff;
                     last_in = now;
                  end
               end
               MODE_NORMAL: begin
                  if (hit) begin
                     led_in  = (led_ff == lit) ? dark : lit;
                     last_in = now;
                  end
               end
               MODE_SEND: begin
                  running_in = 1'b1;
                  step_in    = step_cur;
                  if (!running_ff) begin
                     start_in = now;
                  end
                  if (hit) begin
                     start_in = now;
                     led_in   = step_cur[0] ? dark : lit;
                     step_in  = step_next;
                     if (step_next >= cfg.burst_step_count) begin
                        running_in = 1'b0;
                        mode_in    = saved_ff;
                     end
                  end
               end
               default: led_in = dark;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff     <= 1'b0;
         mode_ff    <= MODE_START;
         saved_ff   <= MODE_START;
         last_ff    <= '0;
         start_ff   <= '0;
         step_ff    <= 8'd0;
         running_ff <= 1'b0;
      end else begin
         led_ff     <= led_in;
         mode_ff    <= mode_in;
         saved_ff   <= saved_in;
         last_ff    <= last_in;
         start_ff   <= start_in;
         step_ff    <= step_in;
         running_ff <= running_in;
      end
   end

   assign result.pin_level = led_in;
   assign result.mode_now  = mode_in;

endmodule

// ===== rtl/status_led_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Status LED blink pattern driven by polls and mode writes.
// A result is registered in res_ff when its item advances out of the input register.
// Throughput: one item per cycle unless a waiting result stalls on rsp_tready.
// The input register lets a new item in while a result waits on rsp_tready.
// Synchronous active-high reset: modes to starting, LED low, registers to
// their default intervals; no clearing pass.
// ----------------------------------------------------------------------------
module status_led_pattern_generator (
   input  logic                    clock,
   input  logic                    reset,
   // tdata: now_ms[31:0], new_mode[34:32], return_mode[37:35], zero pad
   input  logic [39:0]             req_tdata,
   // tuser: func
   input  logic                    req_tuser,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tdata: pin_level[0], mode_now[3:1], zero pad
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  slpg_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_data
);
   import slpg_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff,  in_valid_in;
   result_type res_ff;
   result_type res_next;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   slpg_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func        <= req_tuser;
         item_ff.now_ms      <= req_tdata[31:0];
         item_ff.new_mode    <= req_tdata[34:32];
         item_ff.return_mode <= req_tdata[37:35];
      end
      if (advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, res_ff.mode_now, res_ff.pin_level};

endmodule
